// File: hw/rtl/pcss_pkg.sv
// ----------------------------------------------------------------------------
// pcss_pkg
// Shared types and constants for the per-channel sample statistics block.
// ----------------------------------------------------------------------------
package pcss_pkg;

  localparam int NUM_CHANNELS_DEF = 2;
  localparam int MAX_SAMPLES      = 65536;

  localparam int WORD_W = 16;
  localparam int VAL_W  = 12;
  localparam int CNT_W  = 17;
  localparam int SUM_W  = 29;
  localparam int STEP_W = 4;

  localparam int CH_LSB = 12;
  localparam int CH_MSB = 14;

  localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CNT_LIMIT =
    CNT_W'((MAX_SAMPLES < CNT_FIELD_MAX) ? MAX_SAMPLES : CNT_FIELD_MAX);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic acc;
    logic div_load;
    logic div_step;
    logic next_ch;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_ch;
  } sts_t;

endpackage

// File: hw/rtl/pcss_ctrl.sv
// ----------------------------------------------------------------------------
// pcss_ctrl
// Sequencer: accepts sample beats, then runs one divide and one result beat
// per channel, then clears the statistics.
// ----------------------------------------------------------------------------
module pcss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last_sample,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  pcss_pkg::sts_t  sts,
  output pcss_pkg::cmd_t  cmd
);
  import pcss_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.acc  = in_valid;
        if (in_valid && in_last_sample) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.last_ch) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.next_ch = 1'b1;
            state_nxt   = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/pcss_dp.sv
// ----------------------------------------------------------------------------
// pcss_dp
// Datapath: per-channel count, sum, min and max registers, a radix-2
// restoring divider for the average and the result register.
// ----------------------------------------------------------------------------
module pcss_dp #(
  parameter int NUM_CHANNELS = pcss_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcss_pkg::cmd_t                cmd,
  output pcss_pkg::sts_t                sts,
  input  logic [pcss_pkg::WORD_W-1:0]   in_sample_word,
  output logic                          out_channel,
  output logic [pcss_pkg::CNT_W-1:0]    out_sample_count,
  output logic [pcss_pkg::VAL_W-1:0]    out_min_value,
  output logic [pcss_pkg::VAL_W-1:0]    out_max_value,
  output logic [pcss_pkg::VAL_W-1:0]    out_average,
  output logic                          out_empty_res,
  output logic                          out_last
);
  import pcss_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
  localparam int TAG_W = CH_MSB - CH_LSB + 1;

  logic [CNT_W-1:0] cnt_r   [NUM_CHANNELS];
  logic [CNT_W-1:0] cnt_nxt [NUM_CHANNELS];
  logic [SUM_W-1:0] sum_r   [NUM_CHANNELS];
  logic [SUM_W-1:0] sum_nxt [NUM_CHANNELS];
  logic [SUM_W:0]   sum_add [NUM_CHANNELS];
  logic [VAL_W-1:0] min_r   [NUM_CHANNELS];
  logic [VAL_W-1:0] min_nxt [NUM_CHANNELS];
  logic [VAL_W-1:0] max_r   [NUM_CHANNELS];
  logic [VAL_W-1:0] max_nxt [NUM_CHANNELS];

  logic [TAG_W-1:0] smp_ch;
  logic [VAL_W-1:0] smp_val;

  logic [CH_W-1:0]   idx_r;
  logic [CNT_W-1:0]  rem_r;
  logic [VAL_W-1:0]  dvd_r;
  logic              ovf_r;
  logic [STEP_W-1:0] step_r;

  logic [CNT_W-1:0]  cnt_sel;
  logic [SUM_W-1:0]  sum_sel;
  logic [CNT_W:0]    rem_sh;
  logic              fits;
  logic              empty;

  assign smp_ch  = in_sample_word[CH_MSB:CH_LSB];
  assign smp_val = in_sample_word[VAL_W-1:0];

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      cnt_nxt[k] = cnt_r[k];
      sum_nxt[k] = sum_r[k];
      min_nxt[k] = min_r[k];
      max_nxt[k] = max_r[k];
      sum_add[k] = {1'b0, sum_r[k]} + (SUM_W + 1)'(smp_val);
      if (cmd.clear) begin
        cnt_nxt[k] = '0;
        sum_nxt[k] = '0;
        min_nxt[k] = VAL_MAX;
        max_nxt[k] = '0;
      end else if (cmd.acc && smp_ch == TAG_W'(k)) begin
        if (cnt_r[k] < CNT_LIMIT) begin
          cnt_nxt[k] = cnt_r[k] + CNT_W'(1);
        end
        if (sum_add[k] > {1'b0, SUM_MAX}) begin
          sum_nxt[k] = SUM_MAX;
        end else begin
          sum_nxt[k] = sum_add[k][SUM_W-1:0];
        end
        if (smp_val < min_r[k]) begin
          min_nxt[k] = smp_val;
        end
        if (smp_val > max_r[k]) begin
          max_nxt[k] = smp_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        cnt_r[k] <= '0;
        sum_r[k] <= '0;
        min_r[k] <= VAL_MAX;
        max_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
        sum_r[k] <= sum_nxt[k];
        min_r[k] <= min_nxt[k];
        max_r[k] <= max_nxt[k];
      end
    end
  end

  // divider: high part of the sum seeds the remainder, low 12 bits shift in
  assign cnt_sel = cnt_r[idx_r];
  assign sum_sel = sum_r[idx_r];
  assign rem_sh  = {rem_r, dvd_r[VAL_W-1]};
  assign fits    = rem_sh >= {1'b0, cnt_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      step_r <= '0;
    end else begin
      if (cmd.clear) begin
        idx_r <= '0;
      end else if (cmd.next_ch) begin
        idx_r <= idx_r + CH_W'(1);
      end
      if (cmd.div_load) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= sum_sel[SUM_W-1:VAL_W];
      dvd_r <= sum_sel[VAL_W-1:0];
      ovf_r <= sum_sel[SUM_W-1:VAL_W] >= cnt_sel;
    end else if (cmd.div_step) begin
      if (fits) begin
        rem_r <= CNT_W'(rem_sh - {1'b0, cnt_sel});
      end else begin
        rem_r <= rem_sh[CNT_W-1:0];
      end
      dvd_r <= {dvd_r[VAL_W-2:0], fits};
    end
  end

  assign sts.div_done = step_r == STEP_W'(VAL_W - 1);
  assign sts.last_ch  = idx_r == LAST_CH;

  assign empty            = cnt_sel == '0;
  assign out_channel      = idx_r[0];
  assign out_sample_count = cnt_sel;
  assign out_min_value    = min_r[idx_r];
  assign out_max_value    = max_r[idx_r];
  assign out_empty_res    = empty;
  assign out_last         = sts.last_ch;
  assign out_average      = empty ? '0 : (ovf_r ? VAL_MAX : dvd_r);

endmodule

// File: hw/rtl/per_channel_sample_statistics.sv
// ----------------------------------------------------------------------------
// per_channel_sample_statistics
// Running count, sum, min and max per ADC channel with an end-of-capture
// report of count, min, max and truncated average for every channel.
// ----------------------------------------------------------------------------
// Input channel: one tagged ADC word per beat (bits 14:12 channel, 11:0
// value). Words for channels at or above NUM_CHANNELS are dropped. Ordinary
// samples are taken at one per cycle; in_stall stays low while idle.
// A beat with in_last_sample set is accumulated and starts the report: the
// block raises in_stall and emits NUM_CHANNELS result beats in channel order.
// Each result takes a divider load and then a divide, one quotient bit
// per cycle from a shared restoring divider, so the first result is valid
// once that divide ends after the last sample is accepted, and each further
// result once its divide ends after the previous one is taken.
// out_stall holds the result beat steady; the block waits without limit.
// After the last result beat the statistics clear and input resumes.
// Reset (rst_n low, synchronous) clears all statistics and the sequencer.
// ----------------------------------------------------------------------------
module per_channel_sample_statistics #(
  parameter int NUM_CHANNELS = pcss_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pcss_pkg::WORD_W-1:0]   in_sample_word,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_channel,
  output logic [pcss_pkg::CNT_W-1:0]    out_sample_count,
  output logic [pcss_pkg::VAL_W-1:0]    out_min_value,
  output logic [pcss_pkg::VAL_W-1:0]    out_max_value,
  output logic [pcss_pkg::VAL_W-1:0]    out_average,
  output logic                          out_empty_res,
  output logic                          out_last
);
  import pcss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcss_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_sample (in_last_sample),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  pcss_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample_word   (in_sample_word),
    .out_channel      (out_channel),
    .out_sample_count (out_sample_count),
    .out_min_value    (out_min_value),
    .out_max_value    (out_max_value),
    .out_average      (out_average),
    .out_empty_res    (out_empty_res),
    .out_last         (out_last)
  );

endmodule
